>>> src/tiws_pkg.sv
// ----------------------------------------------------------------------------
// Tomasulo scheduler package
// Shared widths, operation codes, latencies and word types.
// ----------------------------------------------------------------------------
package tiws_pkg;

	localparam int NUM_ST   = 16;
	localparam int ST_W     = 4;
	localparam int TAG_W    = 5;
	localparam int NUM_REGS = 32;
	localparam int REG_W    = 5;
	localparam int RCNT_W   = 6;
	localparam int CNT_W    = 5;
	localparam int IDX_W    = 16;
	localparam int REM_W    = 6;
	localparam int CYC_W    = 32;
	localparam int PADDR_W  = 5;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MULT  = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_LOAD  = 3'd4;
	localparam logic [2:0] OP_STORE = 3'd5;

	localparam logic [2:0] REG_ADD_CNT   = 3'd0;
	localparam logic [2:0] REG_MULT_CNT  = 3'd1;
	localparam logic [2:0] REG_LOAD_CNT  = 3'd2;
	localparam logic [2:0] REG_STORE_CNT = 3'd3;
	localparam logic [2:0] REG_REG_CNT   = 3'd4;

	localparam logic [REM_W-1:0] LAT_ADD  = 6'd2;
	localparam logic [REM_W-1:0] LAT_MULT = 6'd10;
	localparam logic [REM_W-1:0] LAT_DIV  = 6'd40;
	localparam logic [REM_W-1:0] LAT_MEM  = 6'd2;

	function automatic logic [REM_W-1:0] op_latency(input logic [2:0] op);
		case (op)
			OP_ADD, OP_SUB:    op_latency = LAT_ADD;
			OP_MULT:           op_latency = LAT_MULT;
			OP_DIV:            op_latency = LAT_DIV;
			OP_LOAD, OP_STORE: op_latency = LAT_MEM;
			default:           op_latency = '0;
		endcase
	endfunction

	typedef struct packed {
		logic             has_instr;
		logic [2:0]       op;
		logic [REG_W-1:0] dest_reg;
		logic [REG_W-1:0] src1_reg;
		logic [REG_W-1:0] src2_reg;
	} in_word_t;

	typedef struct packed {
		logic             issued;
		logic [ST_W-1:0]  issued_station;
		logic             wb_valid;
		logic [IDX_W-1:0] wb_index;
		logic [CYC_W-1:0] wb_issue_cycle;
		logic [CYC_W-1:0] wb_exec_cycle;
		logic [CYC_W-1:0] wb_write_cycle;
		logic             all_idle;
	} out_word_t;

	typedef struct packed {
		logic             sel_valid;
		logic [ST_W-1:0]  sel_idx;
		logic [CYC_W-1:0] sel_time;
		logic             free_valid;
		logic [ST_W-1:0]  free_idx;
	} scan_t;

	typedef struct packed {
		logic             wb_en;
		logic [ST_W-1:0]  wb_station;
		logic             step_en;
		logic [CYC_W-1:0] cyc;
		logic             scan_en;
		logic             iss_en;
		logic [ST_W-1:0]  iss_station;
		logic [2:0]       iss_op;
		logic [TAG_W-1:0] iss_t1;
		logic [TAG_W-1:0] iss_t2;
		logic [IDX_W-1:0] iss_index;
		logic [ST_W:0]    kind_lo;
		logic [ST_W:0]    kind_hi;
	} cell_ctl_t;

	typedef struct packed {
		logic             busy;
		logic [IDX_W-1:0] instr_index;
		logic [CYC_W-1:0] issue_time;
		logic [CYC_W-1:0] exec_time;
	} cell_stat_t;

endpackage

>>> src/tiws_cell.sv
// ----------------------------------------------------------------------------
// Reservation station cell
// One station: wakeup, countdown, issue write and one stage of the
// oldest-ready and first-free scan chain.
// ----------------------------------------------------------------------------
module tiws_cell import tiws_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [ST_W-1:0] idx,
	input  cell_ctl_t       ctl,
	input  scan_t           scan_in,
	output scan_t           scan_out,
	output cell_stat_t      stat
);

	logic             busy_q, ready_q;
	logic [1:0]       srcok_q;
	logic [TAG_W-1:0] wait0_q, wait1_q;
	logic [REM_W-1:0] rem_q;
	logic [IDX_W-1:0] index_q;
	logic [CYC_W-1:0] issue_q, exec_q;
	scan_t            scan_q;

	logic             busy_d, ready_d;
	logic [1:0]       srcok_d;
	logic [TAG_W-1:0] wait0_d, wait1_d;
	logic [REM_W-1:0] rem_d;
	logic [IDX_W-1:0] index_d;
	logic [CYC_W-1:0] issue_d, exec_d;
	scan_t            scan_d;
	logic [TAG_W-1:0] wt;
	logic             is_cand, is_free;

	assign wt = {1'b0, ctl.wb_station} + TAG_W'(1);

	always_comb begin
		busy_d  = busy_q;
		ready_d = ready_q;
		srcok_d = srcok_q;
		wait0_d = wait0_q;
		wait1_d = wait1_q;
		rem_d   = rem_q;
		index_d = index_q;
		issue_d = issue_q;
		exec_d  = exec_q;
		if (ctl.step_en) begin
			if (ctl.wb_en && busy_q) begin
				if (wait0_q == wt) srcok_d[0] = 1'b1;
				if (wait1_q == wt) srcok_d[1] = 1'b1;
			end
			if (ctl.wb_en && ctl.wb_station == idx) begin
				busy_d  = 1'b0;
				ready_d = 1'b0;
			end
			if (ready_d && rem_q != '0) begin
				rem_d = rem_q - REM_W'(1);
				if (rem_q == REM_W'(1)) exec_d = ctl.cyc;
			end else if (!ready_d && srcok_d == 2'b11) begin
				ready_d = 1'b1;
			end
		end
		if (ctl.iss_en && ctl.iss_station == idx) begin
			busy_d  = 1'b1;
			index_d = ctl.iss_index;
			rem_d   = op_latency(ctl.iss_op);
			issue_d = ctl.cyc;
			case (ctl.iss_op)
				OP_LOAD: begin
					ready_d = 1'b1;
				end
				OP_STORE: begin
					wait0_d = ctl.iss_t1;
					srcok_d = {1'b1, ctl.iss_t1 == '0};
					ready_d = ctl.iss_t1 == '0;
				end
				default: begin
					wait0_d = ctl.iss_t1;
					wait1_d = ctl.iss_t2;
					srcok_d = {ctl.iss_t2 == '0, ctl.iss_t1 == '0};
					ready_d = ctl.iss_t1 == '0 && ctl.iss_t2 == '0;
				end
			endcase
		end
	end

	assign is_cand = busy_q && rem_q == '0;
	assign is_free = !busy_q && {1'b0, idx} >= ctl.kind_lo && {1'b0, idx} < ctl.kind_hi;

	always_comb begin
		scan_d = scan_in;
		if (is_cand && (!scan_in.sel_valid || issue_q < scan_in.sel_time)) begin
			scan_d.sel_valid = 1'b1;
			scan_d.sel_idx   = idx;
			scan_d.sel_time  = issue_q;
		end
		if (is_free && !scan_in.free_valid) begin
			scan_d.free_valid = 1'b1;
			scan_d.free_idx   = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			ready_q <= 1'b0;
			srcok_q <= '0;
			wait0_q <= '0;
			wait1_q <= '0;
			rem_q   <= '0;
			scan_q  <= '0;
		end else begin
			busy_q  <= busy_d;
			ready_q <= ready_d;
			srcok_q <= srcok_d;
			wait0_q <= wait0_d;
			wait1_q <= wait1_d;
			rem_q   <= rem_d;
			if (ctl.scan_en) scan_q <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		index_q <= index_d;
		issue_q <= issue_d;
		exec_q  <= exec_d;
	end

	assign scan_out         = scan_q;
	assign stat.busy        = busy_q;
	assign stat.instr_index = index_q;
	assign stat.issue_time  = issue_q;
	assign stat.exec_time   = exec_q;

endmodule

>>> src/tiws_regstat.sv
// ----------------------------------------------------------------------------
// Register result status
// Producer tag and ready flag per register, broadcast wakeup, one read port.
// ----------------------------------------------------------------------------
module tiws_regstat import tiws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RCNT_W-1:0] limit,
	input  logic              wb_en,
	input  logic [TAG_W-1:0]  wb_tag,
	input  logic [REG_W-1:0]  rd_addr,
	output logic [TAG_W-1:0]  rd_dep,
	input  logic              wr_en,
	input  logic [REG_W-1:0]  wr_addr,
	input  logic [TAG_W-1:0]  wr_tag
);

	logic [TAG_W-1:0] tag_q [NUM_REGS];
	logic             rdy_q [NUM_REGS];

	always_comb begin
		if ({1'b0, rd_addr} >= limit || rdy_q[rd_addr]) rd_dep = '0;
		else rd_dep = tag_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				tag_q[r] <= '0;
				rdy_q[r] <= 1'b0;
			end
		end else begin
			for (int r = 0; r < NUM_REGS; r++) begin
				if (wb_en && !rdy_q[r] && tag_q[r] == wb_tag) rdy_q[r] <= 1'b1;
			end
			if (wr_en && {1'b0, wr_addr} < limit) begin
				tag_q[wr_addr] <= wr_tag;
				rdy_q[wr_addr] <= 1'b0;
			end
		end
	end

endmodule

>>> src/tomasulo_issue_wakeup_scheduler.sv
// ----------------------------------------------------------------------------
// Tomasulo issue and wakeup scheduler
// Sixteen reservation station cells in a scan chain, register status table,
// per-cycle sequencer and APB configuration registers.
// ----------------------------------------------------------------------------
// Flow: an accepted word passes the writeback, scan, issue and done states;
// its result word is registered on leaving done, which out_ready can hold.
// No new word is taken before then; the scan chain walk takes the longest.
// Reset: all stations free, registers untagged, machine cycle count one,
// configuration at 3/2/2/2 stations and 16 registers.
module tomasulo_issue_wakeup_scheduler import tiws_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_word_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_word_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_WB    = 5'b00010,
		S_SCAN  = 5'b00100,
		S_ISSUE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q;
	in_word_t          in_q;
	logic [ST_W-1:0]   cnt_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [IDX_W-1:0]  icount_q;
	logic              bus_valid_q;
	logic [ST_W-1:0]   bus_tag_q;
	logic [CNT_W-1:0]  add_cnt_q, mult_cnt_q, load_cnt_q, store_cnt_q;
	logic [RCNT_W-1:0] reg_cnt_q;
	logic              wbv_q;
	logic [IDX_W-1:0]  wbidx_q;
	logic [CYC_W-1:0]  wbiss_q, wbexec_q, wbwr_q;
	logic [TAG_W-1:0]  tdest_q, t1_q, t2_q;
	logic              iss_q;
	logic [ST_W-1:0]   iss_st_q;
	out_word_t         out_q;
	logic              out_valid_q;

	cell_ctl_t         ctl;
	scan_t             chain [NUM_ST+1];
	cell_stat_t        stat [NUM_ST];
	logic [NUM_ST-1:0] busy_vec;
	logic [ST_W:0]     b1, b2, b3, b4;
	logic [ST_W:0]     kind_lo, kind_hi;
	logic              kind_ok, do_issue, cfg_wr;
	logic [RCNT_W-1:0] reg_limit;
	logic [REG_W-1:0]  rd_addr;
	logic [TAG_W-1:0]  rd_dep;
	scan_t             last;

	function automatic logic [ST_W:0] cap_st(input logic [ST_W+1:0] v);
		cap_st = (v > (ST_W+2)'(NUM_ST)) ? (ST_W+1)'(NUM_ST) : v[ST_W:0];
	endfunction

	assign b1 = cap_st({1'b0, add_cnt_q});
	assign b2 = cap_st({1'b0, b1} + {1'b0, mult_cnt_q});
	assign b3 = cap_st({1'b0, b2} + {1'b0, load_cnt_q});
	assign b4 = cap_st({1'b0, b3} + {1'b0, store_cnt_q});
	assign reg_limit = (reg_cnt_q > RCNT_W'(NUM_REGS)) ? RCNT_W'(NUM_REGS) : reg_cnt_q;

	always_comb begin
		kind_ok = 1'b1;
		kind_lo = '0;
		kind_hi = '0;
		case (in_q.op)
			OP_ADD, OP_SUB: begin
				kind_hi = b1;
			end
			OP_MULT, OP_DIV: begin
				kind_lo = b1;
				kind_hi = b2;
			end
			OP_LOAD: begin
				kind_lo = b2;
				kind_hi = b3;
			end
			OP_STORE: begin
				kind_lo = b3;
				kind_hi = b4;
			end
			default: kind_ok = 1'b0;
		endcase
	end

	assign last     = chain[NUM_ST];
	assign do_issue = in_q.has_instr && kind_ok && last.free_valid;

	always_comb begin
		ctl             = '0;
		ctl.wb_en       = state_q == S_WB && bus_valid_q;
		ctl.wb_station  = bus_tag_q;
		ctl.step_en     = state_q == S_WB;
		ctl.cyc         = cyc_q;
		ctl.scan_en     = state_q == S_SCAN;
		ctl.iss_en      = state_q == S_ISSUE && do_issue;
		ctl.iss_station = last.free_idx;
		ctl.iss_op      = in_q.op;
		ctl.iss_t1      = (in_q.op == OP_STORE) ? tdest_q : t1_q;
		ctl.iss_t2      = t2_q;
		ctl.iss_index   = icount_q;
		ctl.kind_lo     = kind_lo;
		ctl.kind_hi     = kind_hi;
	end

	assign chain[0] = '0;

	for (genvar g = 0; g < NUM_ST; g++) begin : g_cell
		tiws_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (ST_W'(g)),
			.ctl      (ctl),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1]),
			.stat     (stat[g])
		);
		assign busy_vec[g] = stat[g].busy;
	end

	always_comb begin
		case (cnt_q)
			ST_W'(0): rd_addr = in_q.dest_reg;
			ST_W'(1): rd_addr = in_q.src1_reg;
			default:  rd_addr = in_q.src2_reg;
		endcase
	end

	tiws_regstat u_regstat (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (reg_limit),
		.wb_en   (ctl.wb_en),
		.wb_tag  ({1'b0, bus_tag_q} + TAG_W'(1)),
		.rd_addr (rd_addr),
		.rd_dep  (rd_dep),
		.wr_en   (ctl.iss_en && in_q.op != OP_STORE),
		.wr_addr (in_q.dest_reg),
		.wr_tag  ({1'b0, last.free_idx} + TAG_W'(1))
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[4:2])
			REG_ADD_CNT:   prdata = {27'd0, add_cnt_q};
			REG_MULT_CNT:  prdata = {27'd0, mult_cnt_q};
			REG_LOAD_CNT:  prdata = {27'd0, load_cnt_q};
			REG_STORE_CNT: prdata = {27'd0, store_cnt_q};
			REG_REG_CNT:   prdata = {26'd0, reg_cnt_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_cnt_q   <= 5'd3;
			mult_cnt_q  <= 5'd2;
			load_cnt_q  <= 5'd2;
			store_cnt_q <= 5'd2;
			reg_cnt_q   <= 6'd16;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_ADD_CNT:   add_cnt_q   <= pwdata[CNT_W-1:0];
				REG_MULT_CNT:  mult_cnt_q  <= pwdata[CNT_W-1:0];
				REG_LOAD_CNT:  load_cnt_q  <= pwdata[CNT_W-1:0];
				REG_STORE_CNT: store_cnt_q <= pwdata[CNT_W-1:0];
				REG_REG_CNT:   reg_cnt_q   <= pwdata[RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cyc_q       <= CYC_W'(1);
			icount_q    <= '0;
			bus_valid_q <= 1'b0;
			bus_tag_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_WB;
				end
				S_WB: begin
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_q + ST_W'(1);
					if (cnt_q == ST_W'(NUM_ST - 1)) state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					bus_valid_q <= last.sel_valid;
					bus_tag_q   <= last.sel_valid ? last.sel_idx : '0;
					if (do_issue) icount_q <= icount_q + IDX_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						cyc_q   <= cyc_q + CYC_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) in_q <= in_data;
		if (state_q == S_WB) begin
			wbv_q    <= bus_valid_q;
			wbidx_q  <= bus_valid_q ? stat[bus_tag_q].instr_index : '0;
			wbiss_q  <= bus_valid_q ? stat[bus_tag_q].issue_time : '0;
			wbexec_q <= bus_valid_q ? stat[bus_tag_q].exec_time : '0;
			wbwr_q   <= bus_valid_q ? cyc_q : '0;
		end
		if (state_q == S_SCAN) begin
			if (cnt_q == ST_W'(0)) tdest_q <= rd_dep;
			if (cnt_q == ST_W'(1)) t1_q <= rd_dep;
			if (cnt_q == ST_W'(2)) t2_q <= rd_dep;
		end
		if (state_q == S_ISSUE) begin
			iss_q    <= do_issue;
			iss_st_q <= do_issue ? last.free_idx : '0;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q.issued         <= iss_q;
			out_q.issued_station <= iss_st_q;
			out_q.wb_valid       <= wbv_q;
			out_q.wb_index       <= wbidx_q;
			out_q.wb_issue_cycle <= wbiss_q;
			out_q.wb_exec_cycle  <= wbexec_q;
			out_q.wb_write_cycle <= wbwr_q;
			out_q.all_idle       <= ~|busy_vec;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("input taken outside idle");

	a_bus_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && bus_valid_q) |-> busy_vec[bus_tag_q])
		else $error("pending broadcast names a free station");

	a_issue_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE && do_issue) |-> !busy_vec[last.free_idx])
		else $error("issue into a busy station");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE && do_issue) |=> busy_vec[$past(last.free_idx)])
		else $error("issued station not marked busy");

endmodule

>>> tb/tomasulo_issue_wakeup_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Tomasulo issue and wakeup scheduler testbench
// Drives machine-cycle words under several station and register settings,
// predicts every result word from a cycle-accurate scheduler model and
// compares field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tomasulo_issue_wakeup_scheduler_tb;
	import tiws_pkg::*;

	localparam int WATCH_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 30;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_word_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_word_t          out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	tomasulo_issue_wakeup_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_word_t  cycle_q[$];
	out_word_t sched_q[$];
	int        send_idle;
	int        recv_stall;
	int        errors;
	int        watch;

	// scheduler shadow state
	logic [CNT_W-1:0]  kind_cnt[4];
	logic [RCNT_W-1:0] reg_cnt;
	logic              rs_busy[NUM_ST];
	logic              rs_rdy[NUM_ST];
	logic [1:0]        rs_ok[NUM_ST];
	logic [TAG_W-1:0]  rs_wait[NUM_ST][2];
	logic [REM_W-1:0]  rs_left[NUM_ST];
	logic [IDX_W-1:0]  rs_seq[NUM_ST];
	logic [CYC_W-1:0]  rs_t_iss[NUM_ST];
	logic [CYC_W-1:0]  rs_t_exe[NUM_ST];
	logic [TAG_W-1:0]  fp_tag[NUM_REGS];
	logic              fp_rdy[NUM_REGS];
	logic [CYC_W-1:0]  mcycle;
	logic [IDX_W-1:0]  seq_no;
	logic              bus_v;
	logic [ST_W-1:0]   bus_st;

	function automatic int station_kind(int s);
		int b1, b2, b3, b4;
		b1 = (kind_cnt[0] > NUM_ST) ? NUM_ST : kind_cnt[0];
		b2 = (b1 + kind_cnt[1] > NUM_ST) ? NUM_ST : b1 + kind_cnt[1];
		b3 = (b2 + kind_cnt[2] > NUM_ST) ? NUM_ST : b2 + kind_cnt[2];
		b4 = (b3 + kind_cnt[3] > NUM_ST) ? NUM_ST : b3 + kind_cnt[3];
		if (s < b1) return 0;
		if (s < b2) return 1;
		if (s < b3) return 2;
		if (s < b4) return 3;
		return 4;
	endfunction

	function automatic int regs_tracked();
		return (reg_cnt > NUM_REGS) ? NUM_REGS : reg_cnt;
	endfunction

	function automatic logic [TAG_W-1:0] pending_tag(int r);
		if (r >= regs_tracked() || fp_rdy[r]) return '0;
		return fp_tag[r];
	endfunction

	function automatic void rename_reg(int r, int s);
		if (r < regs_tracked()) begin
			fp_tag[r] = TAG_W'(s + 1);
			fp_rdy[r] = 1'b0;
		end
	endfunction

	function automatic void sched_reset();
		kind_cnt = '{5'd3, 5'd2, 5'd2, 5'd2};
		reg_cnt = 6'd16;
		for (int s = 0; s < NUM_ST; s++) begin
			rs_busy[s] = 0; rs_rdy[s] = 0; rs_ok[s] = 0;
			rs_wait[s][0] = 0; rs_wait[s][1] = 0; rs_left[s] = 0;
			rs_seq[s] = 0; rs_t_iss[s] = 0; rs_t_exe[s] = 0;
		end
		for (int r = 0; r < NUM_REGS; r++) begin
			fp_tag[r] = 0; fp_rdy[r] = 0;
		end
		mcycle = 1; seq_no = 0; bus_v = 0; bus_st = 0;
	endfunction

	function automatic out_word_t sched_cycle(in_word_t w);
		out_word_t o;
		int best, s, k;
		logic [TAG_W-1:0] wt, t1, t2;
		o = '0;
		best = -1;
		if (bus_v) begin
			wt = TAG_W'(bus_st) + 1'b1;
			for (int r = 0; r < NUM_REGS; r++)
				if (!fp_rdy[r] && fp_tag[r] == wt) fp_rdy[r] = 1'b1;
			for (int i = 0; i < NUM_ST; i++) begin
				if (rs_busy[i]) begin
					if (rs_wait[i][0] == wt) rs_ok[i][0] = 1'b1;
					if (rs_wait[i][1] == wt) rs_ok[i][1] = 1'b1;
				end
			end
			rs_busy[bus_st] = 0;
			rs_rdy[bus_st] = 0;
			o.wb_valid = 1'b1;
			o.wb_index = rs_seq[bus_st];
			o.wb_issue_cycle = rs_t_iss[bus_st];
			o.wb_exec_cycle = rs_t_exe[bus_st];
			o.wb_write_cycle = mcycle;
		end
		for (int i = 0; i < NUM_ST; i++) begin
			if (rs_rdy[i] && rs_left[i] > 0) begin
				rs_left[i]--;
				if (rs_left[i] == 0) rs_t_exe[i] = mcycle;
			end else if (!rs_rdy[i] && rs_ok[i] == 2'b11) begin
				rs_rdy[i] = 1'b1;
			end
		end
		for (int i = 0; i < NUM_ST; i++)
			if (rs_busy[i] && rs_left[i] == 0)
				if (best < 0 || rs_t_iss[i] < rs_t_iss[best]) best = i;
		bus_v = best >= 0;
		bus_st = (best >= 0) ? ST_W'(best) : '0;
		if (w.has_instr) begin
			case (w.op)
				OP_ADD, OP_SUB: k = 0;
				OP_MULT, OP_DIV: k = 1;
				OP_LOAD: k = 2;
				OP_STORE: k = 3;
				default: k = 4;
			endcase
			if (k != 4) begin
				for (s = 0; s < NUM_ST; s++)
					if (!rs_busy[s] && station_kind(s) == k) break;
				if (s < NUM_ST) begin
					rs_busy[s] = 1'b1;
					rs_seq[s] = seq_no;
					case (w.op)
						OP_MULT: rs_left[s] = 6'd10;
						OP_DIV: rs_left[s] = 6'd40;
						default: rs_left[s] = 6'd2;
					endcase
					rs_t_iss[s] = mcycle;
					if (w.op == OP_LOAD) begin
						rs_rdy[s] = 1'b1;
						rename_reg(w.dest_reg, s);
					end else if (w.op == OP_STORE) begin
						t1 = pending_tag(w.dest_reg);
						rs_wait[s][0] = t1;
						rs_ok[s] = {1'b1, t1 == 0};
						rs_rdy[s] = t1 == 0;
					end else begin
						t1 = pending_tag(w.src1_reg);
						t2 = pending_tag(w.src2_reg);
						rs_wait[s][0] = t1;
						rs_wait[s][1] = t2;
						rs_ok[s] = {t2 == 0, t1 == 0};
						rs_rdy[s] = (t1 == 0) && (t2 == 0);
						rename_reg(w.dest_reg, s);
					end
					seq_no++;
					o.issued = 1'b1;
					o.issued_station = ST_W'(s);
				end
			end
		end
		o.all_idle = 1'b1;
		for (int i = 0; i < NUM_ST; i++)
			if (rs_busy[i]) o.all_idle = 1'b0;
		mcycle++;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sched_q.insert(sched_q.size(), sched_cycle(in_data));
			if (!in_valid || in_ready) begin
				if (cycle_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					in_data <= cycle_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n) begin
			out_ready <= $urandom_range(99) >= recv_stall;
			if (out_valid && out_ready) begin
				if (sched_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected word %h", out_data);
				end else begin
					exp_w = sched_q.pop_front();
					if (exp_w.issued !== out_data.issued ||
					    exp_w.issued_station !== out_data.issued_station ||
					    exp_w.wb_valid !== out_data.wb_valid ||
					    exp_w.wb_index !== out_data.wb_index ||
					    exp_w.wb_issue_cycle !== out_data.wb_issue_cycle ||
					    exp_w.wb_exec_cycle !== out_data.wb_exec_cycle ||
					    exp_w.wb_write_cycle !== out_data.wb_write_cycle ||
					    exp_w.all_idle !== out_data.all_idle) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h actual %h", exp_w, out_data);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
		    (cycle_q.size() == 0 && sched_q.size() == 0 && !in_valid)) begin
			watch <= 0;
		end else begin
			watch <= watch + 1;
			if (watch >= WATCH_LIMIT) begin
				$display("FAIL tomasulo_issue_wakeup_scheduler");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00}); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ADD_CNT:   kind_cnt[0] = val[CNT_W-1:0];
			REG_MULT_CNT:  kind_cnt[1] = val[CNT_W-1:0];
			REG_LOAD_CNT:  kind_cnt[2] = val[CNT_W-1:0];
			REG_STORE_CNT: kind_cnt[3] = val[CNT_W-1:0];
			REG_REG_CNT:   reg_cnt = val[RCNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_word(logic hi, logic [2:0] op, logic [4:0] d, logic [4:0] a,
	                         logic [4:0] b);
		in_word_t w;
		w.has_instr = hi; w.op = op; w.dest_reg = d; w.src1_reg = a; w.src2_reg = b;
		@(negedge clk);
		cycle_q.insert(cycle_q.size(), w);
	endtask

	task automatic drain();
		@(negedge clk);
		while (cycle_q.size() > 0 || in_valid || sched_q.size() > 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		int cfg[6][5];
		int r_max;
		logic [2:0] op;
		cfg = '{'{3, 2, 2, 2, 16}, '{16, 16, 16, 16, 32}, '{0, 0, 0, 0, 1},
		        '{1, 1, 1, 1, 2}, '{5, 3, 31, 4, 63}, '{2, 2, 2, 2, 8}};
		errors = 0;
		watch = 0;
		send_idle = 0;
		recv_stall = 0;
		sched_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every op, empty and invalid ops, register extremes, full stations
		push_word(1, OP_LOAD, 5'd1, 5'd0, 5'd0);
		push_word(1, OP_ADD, 5'd2, 5'd1, 5'd0);
		push_word(1, OP_SUB, 5'd3, 5'd2, 5'd1);
		push_word(1, OP_MULT, 5'd4, 5'd3, 5'd2);
		push_word(1, OP_DIV, 5'd5, 5'd4, 5'd4);
		push_word(1, OP_STORE, 5'd5, 5'd0, 5'd0);
		push_word(1, 3'd6, 5'd31, 5'd31, 5'd31);
		push_word(1, 3'd7, 5'd0, 5'd0, 5'd0);
		push_word(0, OP_ADD, 5'd0, 5'd0, 5'd0);
		push_word(1, OP_ADD, 5'd31, 5'd31, 5'd31);
		push_word(1, OP_ADD, 5'd20, 5'd15, 5'd31);
		push_word(1, OP_ADD, 5'd15, 5'd0, 5'd0);
		push_word(1, OP_MULT, 5'd6, 5'd5, 5'd5);
		push_word(1, OP_LOAD, 5'd7, 5'd0, 5'd0);
		push_word(1, OP_LOAD, 5'd8, 5'd0, 5'd0);
		push_word(1, OP_LOAD, 5'd9, 5'd0, 5'd0);
		push_word(1, OP_STORE, 5'd31, 5'd0, 5'd0);
		push_word(1, OP_STORE, 5'd15, 5'd0, 5'd0);
		push_word(1, OP_STORE, 5'd9, 5'd0, 5'd0);
		for (int i = 0; i < 5; i++) push_word(0, 3'd0, 5'd0, 5'd0, 5'd0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			for (int j = 0; j < 5; j++) cfg_write(3'(j), cfg[ph % 6][j]);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 71; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 71; end
				default: begin send_idle = 33; recv_stall = 33; end
			endcase
			r_max = ($urandom_range(9) == 0) ? 31 : 7;
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(19) == 0) op = 3'($urandom_range(6, 7));
				else op = 3'($urandom_range(5));
				push_word($urandom_range(9) != 0, op, 5'($urandom_range(r_max)),
				          5'($urandom_range(r_max)), 5'($urandom_range(r_max)));
			end
			drain();
		end

		if (errors == 0)
			$display("PASS tomasulo_issue_wakeup_scheduler");
		else
			$display("FAIL tomasulo_issue_wakeup_scheduler");
		$finish;
	end

endmodule
